// ----- rtl/core/fpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes, status codes and default sizes of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        FN_ADD    = 4'd0,
        FN_SUB    = 4'd1,
        FN_MUL    = 4'd2,
        FN_DIV    = 4'd3,
        FN_GT     = 4'd4,
        FN_LT     = 4'd5,
        FN_GE     = 4'd6,
        FN_LE     = 4'd7,
        FN_EQ     = 4'd8,
        FN_NE     = 4'd9,
        FN_MIN    = 4'd10,
        FN_MAX    = 4'd11,
        FN_INC    = 4'd12,
        FN_DEC    = 4'd13,
        FN_TO_INT = 4'd14,
        FN_NONE   = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2,
        ST_RSV = 2'd3
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/core/fpa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, with round half
// away from zero and saturation in a final stage.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [WORD_BITS-1:0] i_mag_a,
    input  wire logic [WORD_BITS-1:0] i_mag_b,
    input  wire logic                 i_neg,
    output logic      [WORD_BITS-1:0] o_q,
    output logic                      o_ovf
);
    localparam int W = WORD_BITS;
    localparam int N = WORD_BITS + FRAC_BITS;

    logic [N-1:0] r_num [N];
    logic [N-1:0] r_q   [N];
    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_d   [N];
    logic         r_neg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [N-1:0] p_num;
            logic [N-1:0] p_q;
            logic [W-1:0] p_rem;
            logic [W-1:0] p_d;
            logic         p_neg;
            logic [W:0]   t;
            logic [W:0]   diff;
            logic         ge;
            if (k == 0) begin : g_first
                assign p_num = N'(i_mag_a) << FRAC_BITS;
                assign p_q   = '0;
                assign p_rem = '0;
                assign p_d   = i_mag_b;
                assign p_neg = i_neg;
            end else begin : g_next
                assign p_num = r_num[k-1];
                assign p_q   = r_q[k-1];
                assign p_rem = r_rem[k-1];
                assign p_d   = r_d[k-1];
                assign p_neg = r_neg[k-1];
            end
            assign t    = {p_rem, p_num[N-1]};
            assign ge   = (t >= {1'b0, p_d});
            assign diff = t - {1'b0, p_d};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= {p_num[N-2:0], 1'b0};
                    r_q[k]   <= {p_q[N-2:0], ge};
                    r_rem[k] <= ge ? diff[W-1:0] : t[W-1:0];
                    r_d[k]   <= p_d;
                    r_neg[k] <= p_neg;
                end
            end
        end
    endgenerate

    logic [N:0]   qr;
    logic [N:0]   lim;
    logic [W-1:0] qneg;
    logic         rnd;

    always_comb begin
        rnd  = ({r_rem[N-1], 1'b0} >= {1'b0, r_d[N-1]});
        qr   = {1'b0, r_q[N-1]} + {{N{1'b0}}, rnd};
        lim  = (N+1)'({1'b0, {(W-1){1'b1}}}) + {{N{1'b0}}, r_neg[N-1]};
        qneg = (~qr[W-1:0]) + {{(W-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (qr > lim) begin
                o_ovf <= 1'b1;
                o_q   <= lim[W-1:0];
            end else begin
                o_ovf <= 1'b0;
                o_q   <= r_neg[N-1] ? qneg : qr[W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fixed_point_q24_8_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed fixed-point ALU, Q24.8 by default, fully pipelined.
//
// Input stream: tuser carries the opcode, tdata carries operand_a in the
// low word and operand_b in the next word. Output stream: tdata carries
// result_value, compare_true and status, one beat per input beat, in order.
// The depth is set by the divider, which resolves one quotient bit per
// stage; every opcode travels the same depth. Throughput is one beat per
// cycle while the receiver does not stall.
// When the receiver stalls while a result waits, the whole pipeline holds
// and tready drops; nothing is lost or repeated. Multiply and divide round
// half away from zero and saturate with overflow status; division by zero
// gives status 2. A synchronous active-low reset empties the pipeline.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // operand_a, operand_b
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // func
    input  wire logic [3:0]                          i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // result_value, compare_true, status
    output logic      [((WORD_BITS+3+7)/8)*8-1:0]    o_m_axis_tdata
);
    import fpa_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int N  = WORD_BITS + FRAC_BITS;
    localparam int L  = N + 1;
    localparam int H  = (WORD_BITS + 1) / 2;
    localparam int OW = ((WORD_BITS + 3 + 7) / 8) * 8;
    localparam logic [W-1:0]   MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] HALF = ({{(2*W-1){1'b0}}, 1'b1} << FRAC_BITS) >> 1;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage a
    logic         r_a_vld;
    t_func        r_a_func;
    logic [W-1:0] r_a_a, r_a_b, r_a_ma, r_a_mb;
    logic         r_a_neg;
    logic [W-1:0] in_a, in_b;

    assign in_a = i_s_axis_tdata[W-1:0];
    assign in_b = i_s_axis_tdata[2*W-1:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_func <= t_func'(i_s_axis_tuser);
            r_a_a    <= in_a;
            r_a_b    <= in_b;
            r_a_ma   <= in_a[W-1] ? (~in_a + {{(W-1){1'b0}}, 1'b1}) : in_a;
            r_a_mb   <= in_b[W-1] ? (~in_b + {{(W-1){1'b0}}, 1'b1}) : in_b;
            r_a_neg  <= in_a[W-1] ^ in_b[W-1];
        end
    end

    // simple operations
    logic [W-1:0] n_sv;
    logic         n_sc;
    t_status      n_ss;
    logic         n_sdiv;
    logic [W-1:0] sum, dif;
    logic         lt_ab, lt_ba;

    always_comb begin
        sum    = r_a_a + r_a_b;
        dif    = r_a_a - r_a_b;
        lt_ab  = $signed(r_a_a) < $signed(r_a_b);
        lt_ba  = $signed(r_a_b) < $signed(r_a_a);
        n_sv   = '0;
        n_sc   = 1'b0;
        n_ss   = ST_OK;
        n_sdiv = 1'b0;
        unique case (r_a_func)
            FN_ADD: begin
                if (r_a_a[W-1] == r_a_b[W-1] && sum[W-1] != r_a_a[W-1]) begin
                    n_ss = ST_OVF;
                    n_sv = r_a_a[W-1] ? MINV : MAXV;
                end else begin
                    n_sv = sum;
                end
            end
            FN_SUB: begin
                if (r_a_a[W-1] != r_a_b[W-1] && dif[W-1] != r_a_a[W-1]) begin
                    n_ss = ST_OVF;
                    n_sv = r_a_a[W-1] ? MINV : MAXV;
                end else begin
                    n_sv = dif;
                end
            end
            FN_MUL: begin
            end
            FN_DIV: begin
                if (r_a_b == '0) begin
                    n_ss = ST_DZ;
                    n_sv = (r_a_a == '0) ? '0 : (r_a_a[W-1] ? MINV : MAXV);
                end else begin
                    n_sdiv = 1'b1;
                end
            end
            FN_GT: n_sc = lt_ba;
            FN_LT: n_sc = lt_ab;
            FN_GE: n_sc = !lt_ab;
            FN_LE: n_sc = !lt_ba;
            FN_EQ: n_sc = (r_a_a == r_a_b);
            FN_NE: n_sc = (r_a_a != r_a_b);
            FN_MIN: n_sv = lt_ab ? r_a_a : r_a_b;
            FN_MAX: n_sv = lt_ba ? r_a_a : r_a_b;
            FN_INC: begin
                if (r_a_a == MAXV) begin
                    n_ss = ST_OVF;
                    n_sv = r_a_a;
                end else begin
                    n_sv = r_a_a + {{(W-1){1'b0}}, 1'b1};
                end
            end
            FN_DEC: begin
                if (r_a_a == MINV) begin
                    n_ss = ST_OVF;
                    n_sv = r_a_a;
                end else begin
                    n_sv = r_a_a - {{(W-1){1'b0}}, 1'b1};
                end
            end
            FN_TO_INT: n_sv = W'($signed(r_a_a) >>> FRAC_BITS);
            default: begin
            end
        endcase
    end

    // multiplier: partial products, sum, round and fit
    logic [2*H-1:0] r_p00, r_p01, r_p10, r_p11;
    logic           r_b_mneg, r_c_mneg;
    logic [2*W-1:0] r_prod;
    logic [2*H-1:0] ea, eb;
    logic [4*H-1:0] psum;
    logic [2*W-1:0] rprod, mlim;
    logic [W-1:0]   mneg;
    logic [W-1:0]   mul_v;
    logic           mul_ovf;

    assign ea = (2*H)'(r_a_ma);
    assign eb = (2*H)'(r_a_mb);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00    <= ea[H-1:0] * eb[H-1:0];
            r_p01    <= ea[H-1:0] * eb[2*H-1:H];
            r_p10    <= ea[2*H-1:H] * eb[H-1:0];
            r_p11    <= ea[2*H-1:H] * eb[2*H-1:H];
            r_b_mneg <= r_a_neg;
            r_prod   <= psum[2*W-1:0];
            r_c_mneg <= r_b_mneg;
        end
    end

    always_comb begin
        psum = {{(2*H){1'b0}}, r_p00}
             + (({{(2*H){1'b0}}, r_p01} + {{(2*H){1'b0}}, r_p10}) << H)
             + {r_p11, {(2*H){1'b0}}};
        rprod = (r_prod + HALF) >> FRAC_BITS;
        mlim  = (2*W)'(MAXV) + {{(2*W-1){1'b0}}, r_c_mneg};
        mneg  = (~rprod[W-1:0]) + {{(W-1){1'b0}}, 1'b1};
        if (rprod > mlim) begin
            mul_ovf = 1'b1;
            mul_v   = mlim[W-1:0];
        end else begin
            mul_ovf = 1'b0;
            mul_v   = r_c_mneg ? mneg : rprod[W-1:0];
        end
    end

    // result line alongside the divider
    logic         r_vld  [L];
    logic [W-1:0] r_sv   [L];
    logic         r_sc   [L];
    t_status      r_ss   [L];
    logic         r_sdiv [L];
    logic         r_smul [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_a_vld;
            for (int i = 1; i < L; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sv[0]   <= n_sv;
            r_sc[0]   <= n_sc;
            r_ss[0]   <= n_ss;
            r_sdiv[0] <= n_sdiv;
            r_smul[0] <= (r_a_func == FN_MUL);
            r_sv[1]   <= r_sv[0];
            r_sc[1]   <= r_sc[0];
            r_ss[1]   <= r_ss[0];
            r_sdiv[1] <= r_sdiv[0];
            r_smul[1] <= r_smul[0];
            r_sv[2]   <= r_smul[1] ? mul_v : r_sv[1];
            r_sc[2]   <= r_sc[1];
            r_ss[2]   <= r_smul[1] ? (mul_ovf ? ST_OVF : ST_OK) : r_ss[1];
            r_sdiv[2] <= r_sdiv[1];
            r_smul[2] <= r_smul[1];
            for (int i = 3; i < L; i++) begin
                r_sv[i]   <= r_sv[i-1];
                r_sc[i]   <= r_sc[i-1];
                r_ss[i]   <= r_ss[i-1];
                r_sdiv[i] <= r_sdiv[i-1];
                r_smul[i] <= r_smul[i-1];
            end
        end
    end

    logic [W-1:0] div_q;
    logic         div_ovf;

    fpa_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag_a (r_a_ma),
        .i_mag_b (r_a_mb),
        .i_neg   (r_a_neg),
        .o_q     (div_q),
        .o_ovf   (div_ovf)
    );

    // output register
    logic         r_out_vld;
    logic [W-1:0] r_out_v;
    logic         r_out_c;
    t_status      r_out_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_v <= r_sdiv[L-1] ? div_q : r_sv[L-1];
            r_out_c <= r_sc[L-1];
            r_out_s <= r_sdiv[L-1] ? (div_ovf ? ST_OVF : ST_OK) : r_ss[L-1];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OW'({r_out_s, r_out_c, r_out_v});

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_c |-> r_out_v == '0 && r_out_s == ST_OK)
        else $error("comparison beat with nonzero value or status");

    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_s == ST_OVF |-> r_out_v == MAXV || r_out_v == MINV)
        else $error("overflow beat not saturated");

    a_no_rsv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_s != ST_RSV)
        else $error("reserved status code");

    a_dz_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_s == ST_DZ |-> !r_out_c)
        else $error("division by zero beat with compare flag");

endmodule
`default_nettype wire
